// File: src/qubit_slot_allocator_top_defines.svh
// ----------------------------------------------------------------------------
// Slot allocator assertion macros
// Shared property wrappers for the slot allocator checker.
// ----------------------------------------------------------------------------
`ifndef QUBIT_SLOT_ALLOCATOR_TOP_DEFINES_SVH
`define QUBIT_SLOT_ALLOCATOR_TOP_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define QSA_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("slot allocator: same-cycle property failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define QSA_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("slot allocator: next-cycle property failed");

`endif

// File: src/qsa_pkg.sv
// ----------------------------------------------------------------------------
// Slot allocator package
// Sizes, codes and the control structs shared by the slot allocator modules.
// ----------------------------------------------------------------------------
package qsa_pkg;

  // Pool size and identifier width.
  localparam int NUM_SLOTS   = 64;
  localparam int IDENT_WIDTH = 32;
  localparam int SLOT_W      = $clog2(NUM_SLOTS);
  localparam int LIMIT_W     = $clog2(NUM_SLOTS + 1);

  // Fixed port widths.
  localparam int CFG_W        = 7;
  localparam int ACTION_W     = 2;
  localparam int SLOT_PORT_W  = 6;
  localparam int IDENT_PORT_W = 32;
  localparam int STATUS_W     = 2;

  typedef enum logic [ACTION_W-1:0] {
    ACT_ALLOC = 2'd0,
    ACT_FREE  = 2'd1,
    ACT_FIND  = 2'd2,
    ACT_REV   = 2'd3
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK       = 2'd0,
    STAT_FULL     = 2'd1,
    STAT_UNMAPPED = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_LOOKUP,
    ST_FINISH
  } state_t;

  // Commands from the sequencer to the slot table.
  typedef struct packed {
    logic                   scan_clear;
    logic                   cmp_en;
    logic [SLOT_W-1:0]      rd_addr;
    logic [LIMIT_W-1:0]     limit;
    logic [IDENT_WIDTH-1:0] key;
    logic                   set_en;
    logic [SLOT_W-1:0]      set_idx;
    logic                   clr_en;
    logic [SLOT_W-1:0]      clr_idx;
  } tbl_cmd_t;

  // Scan results and read data from the slot table.
  typedef struct packed {
    logic                   old_found;
    logic [SLOT_W-1:0]      old_slot;
    logic                   free_found;
    logic [SLOT_W-1:0]      free_slot;
    logic                   rd_taken;
    logic [IDENT_WIDTH-1:0] rd_ident;
  } tbl_stat_t;

endpackage

// File: src/qubit_slot_allocator_top.sv
// ----------------------------------------------------------------------------
// Qubit slot allocator
// Two-way map between identifiers and a fixed pool of 64 slots.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low. Allocate, free and
// slot-of-identifier walk the whole owner memory through its single read
// port, one slot per cycle through one shared comparator, and then pass
// through a drain state, a commit state and the output register. A reverse
// lookup reads one memory entry. Each result beat is shown on status,
// result_slot and result_ident for exactly one cycle with done high; the
// receiver must take it then, as the block cannot hold it. The next command
// may be given in the same cycle that done is high. The slot count register
// is written through cfg_wr_en and cfg_wr_data; the user must write it only
// while the block is idle, as the block itself does not enforce this.
// ----------------------------------------------------------------------------
module qubit_slot_allocator_top (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_wr_en,
  input  logic [qsa_pkg::CFG_W-1:0]          cfg_wr_data,
  input  logic                               start,
  output logic                               busy,
  input  logic [qsa_pkg::ACTION_W-1:0]       action,
  input  logic [qsa_pkg::IDENT_PORT_W-1:0]   ident,
  input  logic [qsa_pkg::SLOT_PORT_W-1:0]    slot_index,
  output logic                               done,
  output logic [qsa_pkg::STATUS_W-1:0]       status,
  output logic [qsa_pkg::SLOT_PORT_W-1:0]    result_slot,
  output logic [qsa_pkg::IDENT_PORT_W-1:0]   result_ident
);

  qsa_pkg::state_t                 state;
  qsa_pkg::state_t                 state_next;
  logic [qsa_pkg::CFG_W-1:0]       slots_in_use;
  qsa_pkg::action_t                act;
  logic [qsa_pkg::IDENT_WIDTH-1:0] key;
  logic [qsa_pkg::SLOT_PORT_W-1:0] idx;
  logic [qsa_pkg::LIMIT_W-1:0]     limit;
  logic [qsa_pkg::LIMIT_W-1:0]     limit_next;
  logic [qsa_pkg::SLOT_W-1:0]      addr;
  logic                            scan_last;
  logic                            idx_ok;
  logic                            accept;
  qsa_pkg::tbl_cmd_t               cmd;
  qsa_pkg::tbl_stat_t              stat;
  qsa_pkg::status_t                res_status;
  logic [qsa_pkg::SLOT_W-1:0]      res_slot;
  logic [qsa_pkg::IDENT_WIDTH-1:0] res_ident;

  assign busy      = (state != qsa_pkg::ST_IDLE);
  assign accept    = start && !busy;
  assign scan_last = (addr == qsa_pkg::SLOT_W'(qsa_pkg::NUM_SLOTS - 1));
  assign idx_ok    = (32'(idx) < qsa_pkg::NUM_SLOTS);

  // Slot count register, saturated to the pool size when a command starts.
  always_ff @(posedge clk) begin
    if (rst) begin
      slots_in_use <= qsa_pkg::CFG_W'(64);
    end else if (cfg_wr_en) begin
      slots_in_use <= cfg_wr_data;
    end
  end

  always_comb begin
    if (32'(slots_in_use) > qsa_pkg::NUM_SLOTS) begin
      limit_next = qsa_pkg::LIMIT_W'(qsa_pkg::NUM_SLOTS);
    end else begin
      limit_next = qsa_pkg::LIMIT_W'(slots_in_use);
    end
  end

  // Command capture.
  always_ff @(posedge clk) begin
    if (accept) begin
      act   <= qsa_pkg::action_t'(action);
      key   <= qsa_pkg::IDENT_WIDTH'(ident);
      idx   <= slot_index;
      limit <= limit_next;
    end
  end

  // Sequencer state and scan address.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= qsa_pkg::ST_IDLE;
      addr  <= '0;
    end else begin
      state <= state_next;
      if (state == qsa_pkg::ST_SCAN) begin
        addr <= addr + qsa_pkg::SLOT_W'(1);
      end else begin
        addr <= '0;
      end
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      qsa_pkg::ST_IDLE: begin
        if (accept) begin
          if (qsa_pkg::action_t'(action) == qsa_pkg::ACT_REV) begin
            state_next = qsa_pkg::ST_LOOKUP;
          end else begin
            state_next = qsa_pkg::ST_SCAN;
          end
        end
      end
      qsa_pkg::ST_SCAN: begin
        if (scan_last) begin
          state_next = qsa_pkg::ST_DRAIN;
        end
      end
      qsa_pkg::ST_DRAIN:  state_next = qsa_pkg::ST_FINISH;
      qsa_pkg::ST_LOOKUP: state_next = qsa_pkg::ST_FINISH;
      qsa_pkg::ST_FINISH: state_next = qsa_pkg::ST_IDLE;
      default:            state_next = qsa_pkg::ST_IDLE;
    endcase
  end

  // Table commands and the outcome of the command in its commit cycle.
  always_comb begin
    cmd            = '0;
    cmd.limit      = limit;
    cmd.key        = key;
    cmd.rd_addr    = addr;
    res_status     = qsa_pkg::STAT_OK;
    res_slot       = '0;
    res_ident      = '0;
    case (state)
      qsa_pkg::ST_IDLE: begin
        cmd.scan_clear = 1'b1;
      end
      qsa_pkg::ST_SCAN: begin
        cmd.cmp_en = 1'b1;
      end
      qsa_pkg::ST_LOOKUP: begin
        cmd.rd_addr = qsa_pkg::SLOT_W'(idx);
      end
      qsa_pkg::ST_FINISH: begin
        case (act)
          qsa_pkg::ACT_ALLOC: begin
            if (stat.free_found) begin
              cmd.set_en  = 1'b1;
              cmd.set_idx = stat.free_slot;
              cmd.clr_en  = stat.old_found;
              cmd.clr_idx = stat.old_slot;
              res_slot    = stat.free_slot;
            end else begin
              res_status = qsa_pkg::STAT_FULL;
            end
          end
          qsa_pkg::ACT_FREE: begin
            if (stat.old_found) begin
              cmd.clr_en  = 1'b1;
              cmd.clr_idx = stat.old_slot;
              res_slot    = stat.old_slot;
            end else begin
              res_status = qsa_pkg::STAT_UNMAPPED;
            end
          end
          qsa_pkg::ACT_FIND: begin
            if (stat.old_found) begin
              res_slot = stat.old_slot;
            end else begin
              res_status = qsa_pkg::STAT_UNMAPPED;
            end
          end
          qsa_pkg::ACT_REV: begin
            if (idx_ok && stat.rd_taken) begin
              res_ident = stat.rd_ident;
            end else begin
              res_status = qsa_pkg::STAT_UNMAPPED;
            end
          end
          default: begin
            res_status = qsa_pkg::STAT_UNMAPPED;
          end
        endcase
      end
      default: begin
        cmd.scan_clear = 1'b0;
      end
    endcase
  end

  // Result beat registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (state == qsa_pkg::ST_FINISH);
    end
  end

  always_ff @(posedge clk) begin
    if (state == qsa_pkg::ST_FINISH) begin
      status       <= res_status;
      result_slot  <= qsa_pkg::SLOT_PORT_W'(res_slot);
      result_ident <= qsa_pkg::IDENT_PORT_W'(res_ident);
    end
  end

  qsa_slot_table u_slot_table (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .stat (stat)
  );

endmodule

// File: src/qsa_slot_table.sv
// ----------------------------------------------------------------------------
// Slot table
// Taken bits, owner memory and the shared compare unit that walks the slots
// one per cycle to find the key's slot and the lowest free slot.
// ----------------------------------------------------------------------------
module qsa_slot_table (
  input  logic                clk,
  input  logic                rst,
  input  qsa_pkg::tbl_cmd_t   cmd,
  output qsa_pkg::tbl_stat_t  stat
);

  logic [qsa_pkg::NUM_SLOTS-1:0]   taken;
  logic [qsa_pkg::IDENT_WIDTH-1:0] owner [qsa_pkg::NUM_SLOTS];
  logic [qsa_pkg::IDENT_WIDTH-1:0] rd_ident;
  logic                            rd_taken;
  logic [qsa_pkg::SLOT_W-1:0]      cmp_idx;
  logic                            cmp_valid;
  logic                            old_found;
  logic [qsa_pkg::SLOT_W-1:0]      old_slot;
  logic                            free_found;
  logic [qsa_pkg::SLOT_W-1:0]      free_slot;
  logic                            key_hit;
  logic                            free_hit;

  // Owner memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.set_en) begin
      owner[cmd.set_idx] <= cmd.key;
    end
    rd_ident <= owner[cmd.rd_addr];
  end

  // Taken bits: release first, then claim, so a claim always wins.
  always_ff @(posedge clk) begin
    if (rst) begin
      taken <= '0;
    end else begin
      if (cmd.clr_en) begin
        taken[cmd.clr_idx] <= 1'b0;
      end
      if (cmd.set_en) begin
        taken[cmd.set_idx] <= 1'b1;
      end
    end
  end

  // The taken bit travels alongside the read data it belongs to.
  always_ff @(posedge clk) begin
    rd_taken <= taken[cmd.rd_addr];
    cmp_idx  <= cmd.rd_addr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cmp_valid <= 1'b0;
    end else begin
      cmp_valid <= cmd.cmp_en;
    end
  end

  // Shared compare unit: one slot per cycle.
  assign key_hit  = rd_taken && (rd_ident == cmd.key);
  assign free_hit = !rd_taken && (qsa_pkg::LIMIT_W'(cmp_idx) < cmd.limit);

  // Keep the first match and the first free slot seen in this scan.
  always_ff @(posedge clk) begin
    if (rst) begin
      old_found  <= 1'b0;
      free_found <= 1'b0;
    end else if (cmd.scan_clear) begin
      old_found  <= 1'b0;
      free_found <= 1'b0;
    end else if (cmp_valid) begin
      if (!old_found && key_hit) begin
        old_found <= 1'b1;
      end
      if (!free_found && free_hit) begin
        free_found <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmp_valid && !old_found && key_hit) begin
      old_slot <= cmp_idx;
    end
    if (cmp_valid && !free_found && free_hit) begin
      free_slot <= cmp_idx;
    end
  end

  assign stat.old_found  = old_found;
  assign stat.old_slot   = old_slot;
  assign stat.free_found = free_found;
  assign stat.free_slot  = free_slot;
  assign stat.rd_taken   = rd_taken;
  assign stat.rd_ident   = rd_ident;

endmodule

// File: src/qsa_checker.sv
// ----------------------------------------------------------------------------
// Slot allocator checker
// Port-level properties of the slot allocator, bound to the top level.
// ----------------------------------------------------------------------------
`include "qubit_slot_allocator_top_defines.svh"

module qsa_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               start,
  input logic                               busy,
  input logic                               done,
  input logic [qsa_pkg::STATUS_W-1:0]       status,
  input logic [qsa_pkg::SLOT_PORT_W-1:0]    result_slot,
  input logic [qsa_pkg::IDENT_PORT_W-1:0]   result_ident
);

  // An accepted command makes the block busy on the next cycle.
  `QSA_ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy)

  // A result beat is shown only once the block has gone idle.
  `QSA_ASSERT_NOW(a_done_idle, clk, rst, done, !busy)

  // One command gives one result beat, never two in a row.
  `QSA_ASSERT_NEXT(a_done_single, clk, rst, done, !done)

  // A failed command carries no slot and no identifier.
  `QSA_ASSERT_NOW(a_fail_zero, clk, rst,
    done && (status != qsa_pkg::STAT_OK), (result_slot == '0) && (result_ident == '0))

  // A reverse lookup that found an owner reports no slot.
  `QSA_ASSERT_NOW(a_ident_no_slot, clk, rst, done && (result_ident != '0), result_slot == '0)

endmodule

bind qubit_slot_allocator_top qsa_checker u_qsa_checker (.*);

// File: tb/qubit_slot_allocator_top_tb.sv
// ----------------------------------------------------------------------------
// Slot allocator testbench
// Drives allocate, free and both lookups through the start/busy handshake,
// predicts every reply from a private copy of the slot map and checks each
// done beat against it, over several slot-count settings and idle patterns.
// ----------------------------------------------------------------------------
module qubit_slot_allocator_top_tb;

  // Predicts the reply of every accepted command and checks the done beats.
  class slot_map_checker;
    typedef struct {
      qsa_pkg::status_t                 status;
      logic [qsa_pkg::SLOT_PORT_W-1:0]  slot;
      logic [qsa_pkg::IDENT_PORT_W-1:0] ident;
    } reply_t;

    bit                              taken [qsa_pkg::NUM_SLOTS];
    logic [qsa_pkg::IDENT_WIDTH-1:0] owner [qsa_pkg::NUM_SLOTS];
    int                              slot_count;
    reply_t                          pending_replies [$];
    int unsigned                     mismatches;

    function new();
      slot_count = qsa_pkg::NUM_SLOTS;
      mismatches = 0;
      foreach (taken[i]) begin
        taken[i] = 1'b0;
        owner[i] = '0;
      end
    endfunction

    // Counts above the pool size search the whole pool.
    function void set_slot_count(logic [qsa_pkg::CFG_W-1:0] value);
      slot_count = (value > qsa_pkg::NUM_SLOTS) ? qsa_pkg::NUM_SLOTS : int'(value);
    endfunction

    // Slot held by an identifier, or -1 when it holds none.
    function int holder_of(logic [qsa_pkg::IDENT_WIDTH-1:0] id);
      for (int s = 0; s < qsa_pkg::NUM_SLOTS; s++) begin
        if (taken[s] && owner[s] == id) return s;
      end
      return -1;
    endfunction

    function void note_command(qsa_pkg::action_t act,
                               logic [qsa_pkg::IDENT_PORT_W-1:0] id,
                               logic [qsa_pkg::SLOT_PORT_W-1:0] idx);
      reply_t r;
      int     s;
      int     prev;
      r.status = qsa_pkg::STAT_OK;
      r.slot   = '0;
      r.ident  = '0;
      case (act)
        qsa_pkg::ACT_ALLOC: begin
          s = 0;
          while (s < slot_count && taken[s]) s++;
          if (s >= slot_count) begin
            r.status = qsa_pkg::STAT_FULL;
          end else begin
            // The old slot is released only after the scan picked a new one.
            prev = holder_of(id);
            if (prev >= 0) taken[prev] = 1'b0;
            taken[s] = 1'b1;
            owner[s] = id;
            r.slot   = qsa_pkg::SLOT_PORT_W'(s);
          end
        end
        qsa_pkg::ACT_FREE: begin
          prev = holder_of(id);
          if (prev >= 0) begin
            taken[prev] = 1'b0;
            r.slot      = qsa_pkg::SLOT_PORT_W'(prev);
          end else begin
            r.status = qsa_pkg::STAT_UNMAPPED;
          end
        end
        qsa_pkg::ACT_FIND: begin
          prev = holder_of(id);
          if (prev >= 0) r.slot = qsa_pkg::SLOT_PORT_W'(prev);
          else r.status = qsa_pkg::STAT_UNMAPPED;
        end
        default: begin
          if (taken[idx]) r.ident = owner[idx];
          else r.status = qsa_pkg::STAT_UNMAPPED;
        end
      endcase
      pending_replies.push_back(r);
    endfunction

    function void check_reply(logic [qsa_pkg::STATUS_W-1:0] st,
                              logic [qsa_pkg::SLOT_PORT_W-1:0] sl,
                              logic [qsa_pkg::IDENT_PORT_W-1:0] id);
      reply_t e;
      if (pending_replies.size() == 0) begin
        $error("unexpected result beat: status=%0d result_slot=%0d result_ident=%h",
               st, sl, id);
        mismatches++;
        return;
      end
      e = pending_replies.pop_front();
      if (st !== e.status) begin
        $error("status: expected %0d, actual %0d", e.status, st);
        mismatches++;
      end
      if (sl !== e.slot) begin
        $error("result_slot: expected %0d, actual %0d", e.slot, sl);
        mismatches++;
      end
      if (id !== e.ident) begin
        $error("result_ident: expected %h, actual %h", e.ident, id);
        mismatches++;
      end
    endfunction
  endclass

  logic                             clk          = 1'b0;
  logic                             rst          = 1'b1;
  logic                             cfg_wr_en    = 1'b0;
  logic [qsa_pkg::CFG_W-1:0]        cfg_wr_data  = '0;
  logic                             start        = 1'b0;
  logic                             busy;
  logic [qsa_pkg::ACTION_W-1:0]     action       = '0;
  logic [qsa_pkg::IDENT_PORT_W-1:0] ident        = '0;
  logic [qsa_pkg::SLOT_PORT_W-1:0]  slot_index   = '0;
  logic                             done;
  logic [qsa_pkg::STATUS_W-1:0]     status;
  logic [qsa_pkg::SLOT_PORT_W-1:0]  result_slot;
  logic [qsa_pkg::IDENT_PORT_W-1:0] result_ident;

  slot_map_checker                  sb;
  int                               sender_idle_pct = 0;
  logic [qsa_pkg::IDENT_PORT_W-1:0] id_pool [80];

  qubit_slot_allocator_top u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .start        (start),
    .busy         (busy),
    .action       (action),
    .ident        (ident),
    .slot_index   (slot_index),
    .done         (done),
    .status       (status),
    .result_slot  (result_slot),
    .result_ident (result_ident)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Every done beat is taken on the edge that ends its cycle.
  always @(posedge clk) begin
    if (!rst && done) sb.check_reply(status, result_slot, result_ident);
  end

  // Presents one command, with a random gap first, and holds it until taken.
  task automatic issue_command(qsa_pkg::action_t act,
                               logic [qsa_pkg::IDENT_PORT_W-1:0] id,
                               logic [qsa_pkg::SLOT_PORT_W-1:0] idx);
    if (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
    end
    start      <= 1'b1;
    action     <= act;
    ident      <= id;
    slot_index <= idx;
    do @(posedge clk); while (busy);
    sb.note_command(act, id, idx);
  endtask

  // Waits until every reply has come back and the block is idle.
  task automatic drain_replies();
    start <= 1'b0;
    while (sb.pending_replies.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_slot_count(logic [qsa_pkg::CFG_W-1:0] value);
    drain_replies();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.set_slot_count(value);
  endtask

  // Mostly commands on a small set of identifiers, so that allocations,
  // moves, frees and lookups hit; one in ten uses a fresh identifier.
  task automatic run_random_phase(int n_items);
    int                               pick;
    int                               pool_n;
    qsa_pkg::action_t                 act;
    logic [qsa_pkg::IDENT_PORT_W-1:0] id;
    logic [qsa_pkg::SLOT_PORT_W-1:0]  idx;
    pool_n = $urandom_range(80, 4);
    foreach (id_pool[i]) begin
      if ($urandom_range(3) == 0) id_pool[i] = $urandom;
    end
    for (int n = 0; n < n_items; n++) begin
      pick = $urandom_range(99);
      if (pick < 45) act = qsa_pkg::ACT_ALLOC;
      else if (pick < 65) act = qsa_pkg::ACT_FREE;
      else if (pick < 82) act = qsa_pkg::ACT_FIND;
      else act = qsa_pkg::ACT_REV;
      if ($urandom_range(9) == 0) id = $urandom;
      else id = id_pool[$urandom_range(pool_n - 1)];
      if (act == qsa_pkg::ACT_REV && sb.slot_count > 0 && $urandom_range(9) < 7)
        idx = qsa_pkg::SLOT_PORT_W'($urandom_range(sb.slot_count - 1));
      else
        idx = qsa_pkg::SLOT_PORT_W'($urandom_range(qsa_pkg::NUM_SLOTS - 1));
      issue_command(act, id, idx);
    end
  endtask

  // Generous upper bound on the whole run.
  initial begin
    #2000000;
    $display("FAIL qubit_slot_allocator_top");
    $finish;
  end

  initial begin
    logic [qsa_pkg::CFG_W-1:0] phase_count [8];
    int                        phase_idle  [4];
    phase_count = '{7'd127, 7'd7, 7'd1, 7'd64, 7'd0, 7'd40, 7'd65, 7'd3};
    phase_idle  = '{0, 76, 0, 20};
    sb = new();
    foreach (id_pool[i]) id_pool[i] = $urandom;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Lookups and frees on an empty map, then moves of a mapped identifier.
    issue_command(qsa_pkg::ACT_FIND,  32'h0000_0000, 6'h3F);
    issue_command(qsa_pkg::ACT_FREE,  32'hFFFF_FFFF, 6'h00);
    issue_command(qsa_pkg::ACT_REV,   32'hFFFF_FFFF, 6'd0);
    issue_command(qsa_pkg::ACT_REV,   32'h0000_0000, 6'd63);
    issue_command(qsa_pkg::ACT_ALLOC, 32'h0000_0000, 6'h3F);
    issue_command(qsa_pkg::ACT_ALLOC, 32'hFFFF_FFFF, 6'h00);
    issue_command(qsa_pkg::ACT_ALLOC, 32'h0000_0000, 6'h2A);
    issue_command(qsa_pkg::ACT_FIND,  32'h0000_0000, 6'h15);
    issue_command(qsa_pkg::ACT_REV,   32'h0000_0000, 6'd0);
    issue_command(qsa_pkg::ACT_REV,   32'h0000_0000, 6'd2);
    issue_command(qsa_pkg::ACT_REV,   32'h0000_0000, 6'd1);
    issue_command(qsa_pkg::ACT_FREE,  32'hFFFF_FFFF, 6'h3F);
    issue_command(qsa_pkg::ACT_FREE,  32'hFFFF_FFFF, 6'h00);

    // One slot: the pool fills, and a held slot above the count stays visible.
    write_slot_count(7'd1);
    issue_command(qsa_pkg::ACT_ALLOC, 32'hA5A5_A5A5, 6'h00);
    issue_command(qsa_pkg::ACT_ALLOC, 32'h5A5A_5A5A, 6'h00);
    issue_command(qsa_pkg::ACT_ALLOC, 32'h0000_0000, 6'h00);
    issue_command(qsa_pkg::ACT_FIND,  32'h0000_0000, 6'h00);
    issue_command(qsa_pkg::ACT_REV,   32'h0000_0000, 6'd2);

    // Zero slots: allocation always fails, frees still work.
    write_slot_count(7'd0);
    issue_command(qsa_pkg::ACT_ALLOC, 32'h1234_5678, 6'h00);
    issue_command(qsa_pkg::ACT_FREE,  32'h0000_0000, 6'h00);

    // Count above the pool size.
    write_slot_count(7'd127);
    issue_command(qsa_pkg::ACT_ALLOC, 32'h5A5A_5A5A, 6'h00);
    issue_command(qsa_pkg::ACT_REV,   32'h0000_0000, 6'd1);

    // Random phases over several counts and sender idle patterns.
    for (int p = 0; p < 8; p++) begin
      write_slot_count(phase_count[p]);
      sender_idle_pct = phase_idle[p % 4];
      run_random_phase(135);
    end

    drain_replies();
    repeat (70) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending_replies.size() == 0) begin
      $display("PASS qubit_slot_allocator_top");
    end else begin
      $display("FAIL qubit_slot_allocator_top");
    end
    $finish;
  end
endmodule

// File: filelist.f
+incdir+src
src/qsa_pkg.sv
src/qsa_slot_table.sv
src/qubit_slot_allocator_top.sv
src/qsa_checker.sv
tb/qubit_slot_allocator_top_tb.sv
